// ----- sv/swlrl_pkg.sv -----
`default_nettype none
package swlrl_pkg;

  // default sizes
  localparam int NUM_ENTRIES_DEF = 64;
  localparam int MAX_LOG_DEF     = 32;
  localparam int KEY_BITS_DEF    = 32;

  // configuration register map
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_REQ_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEN   = 1'b1;
  localparam int CFG_DATA_W = 16;

  // reset values of the registers
  localparam logic [5:0]  REQ_LIMIT_RST = 6'd10;
  localparam logic [15:0] WIN_LEN_RST   = 16'd60;

  // saturation of the reported count
  localparam int COUNT_SAT = 63;

  // outcome of the client lookup, carried with each queued job
  typedef struct packed {
    logic is_new;
    logic is_full;
  } job_flags_t;

endpackage
`default_nettype wire

// ----- sv/swlrl_front.sv -----
`default_nettype none
module swlrl_front #(
  parameter int NUM_ENTRIES = swlrl_pkg::NUM_ENTRIES_DEF,
  parameter int KEY_BITS    = swlrl_pkg::KEY_BITS_DEF,
  localparam int IDX_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [31:0]             client_key,
  input  wire logic [31:0]             now_seconds,
  output logic                         q_push,
  input  wire logic                    q_full,
  output logic [IDX_W-1:0]             q_idx,
  output swlrl_pkg::job_flags_t        q_flags,
  output logic [31:0]                  q_now
);

  localparam int FILL_W = $clog2(NUM_ENTRIES + 1);

  typedef enum logic [2:0] {F_IDLE, F_READ, F_CMP, F_MISS, F_PUSH} fstate_t;

  fstate_t               state;
  logic [KEY_BITS-1:0]   key_q;
  logic [IDX_W-1:0]      scan;
  logic [FILL_W-1:0]     fill;
  logic [KEY_BITS-1:0]   rd_key;
  logic                  has_free;

  // client keys; entries are claimed in order so used ones sit below fill
  logic [KEY_BITS-1:0]   key_mem [NUM_ENTRIES];

  assign has_free = (fill != FILL_W'(NUM_ENTRIES));
  assign in_stall = (state != F_IDLE);
  assign q_push   = (state == F_PUSH) && !q_full;

  // key store, one read and one write port
  always_ff @(posedge clk) begin
    rd_key <= key_mem[scan];
    if (state == F_MISS && has_free) begin
      key_mem[IDX_W'(fill)] <= key_q;
    end
  end

  // lookup sequencer: scans used entries one at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      fill  <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            key_q <= KEY_BITS'(client_key);
            q_now <= now_seconds;
            scan  <= '0;
            state <= (fill == '0) ? F_MISS : F_READ;
          end
        end
        F_READ: state <= F_CMP;
        F_CMP: begin
          if (rd_key == key_q) begin
            q_idx   <= scan;
            q_flags <= '{is_new: 1'b0, is_full: 1'b0};
            state   <= F_PUSH;
          end else if (FILL_W'(scan) + FILL_W'(1) == fill) begin
            state <= F_MISS;
          end else begin
            scan  <= scan + IDX_W'(1);
            state <= F_READ;
          end
        end
        F_MISS: begin
          // claim lowest free entry, or report a full table
          q_idx <= IDX_W'(fill);
          if (has_free) begin
            fill    <= fill + FILL_W'(1);
            q_flags <= '{is_new: 1'b1, is_full: 1'b0};
          end else begin
            q_flags <= '{is_new: 1'b0, is_full: 1'b1};
          end
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/swlrl_queue.sv -----
`default_nettype none
module swlrl_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] data_in,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      data_out,
  output logic                  empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       level;

  assign full     = (level == 2'd2);
  assign empty    = (level == 2'd0);
  assign data_out = slots[rd_ptr];

  // two-deep word queue
  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= data_in;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && !empty) rd_ptr <= ~rd_ptr;
      level <= level + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule
`default_nettype wire

// ----- sv/swlrl_back.sv -----
`default_nettype none
module swlrl_back #(
  parameter int NUM_ENTRIES = swlrl_pkg::NUM_ENTRIES_DEF,
  parameter int MAX_LOG     = swlrl_pkg::MAX_LOG_DEF,
  localparam int IDX_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_empty,
  output logic                       q_pop,
  input  wire logic [IDX_W-1:0]      q_idx,
  input  wire swlrl_pkg::job_flags_t q_flags,
  input  wire logic [31:0]           q_now,
  input  wire logic [5:0]            req_limit,
  input  wire logic [15:0]           win_len,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       allowed,
  output logic                       table_full,
  output logic [5:0]                 logged_count
);

  localparam int CNT_W  = $clog2(MAX_LOG + 1);
  localparam int DEPTH  = NUM_ENTRIES * MAX_LOG;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    B_IDLE, B_CNT_RD, B_CNT_GOT, B_LOG_RD, B_LOG_CHK, B_DECIDE, B_OUT
  } bstate_t;

  bstate_t           state;
  logic [IDX_W-1:0]  ent;
  logic [31:0]       now_q;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  slot;
  logic [CNT_W-1:0]  kept;
  logic [CNT_W-1:0]  cnt_rd;
  logic [31:0]       t_rd;

  logic              keep;
  logic              allow_now;
  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  kept_final;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_en;
  logic [31:0]       wr_data;

  // per-entry log length and the time logs
  logic [CNT_W-1:0]  cnt_mem  [NUM_ENTRIES];
  logic [31:0]       time_mem [DEPTH];

  // compaction test and admission decision
  always_comb begin
    keep      = (now_q - t_rd) < {16'd0, win_len};
    limit     = (32'(req_limit) > 32'(MAX_LOG)) ? CNT_W'(MAX_LOG)
                                                : CNT_W'(req_limit);
    allow_now = (kept < limit);
    kept_final = allow_now ? kept + CNT_W'(1) : kept;
    rd_addr   = ADDR_W'(ent) * ADDR_W'(MAX_LOG) + ADDR_W'(slot);
    wr_addr   = ADDR_W'(ent) * ADDR_W'(MAX_LOG) + ADDR_W'(kept);
    wr_en     = (state == B_LOG_CHK && keep) || (state == B_DECIDE && allow_now);
    wr_data   = (state == B_DECIDE) ? now_q : t_rd;
  end

  assign q_pop     = (state == B_IDLE) && !q_empty;
  assign out_valid = (state == B_OUT);

  // memories
  always_ff @(posedge clk) begin
    cnt_rd <= cnt_mem[ent];
    t_rd   <= time_mem[rd_addr];
    if (state == B_DECIDE) cnt_mem[ent] <= kept_final;
    if (wr_en) time_mem[wr_addr] <= wr_data;
  end

  // log sequencer: reads each stored time, then tests it and keeps it if it is still in the window
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      kept  <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            ent   <= q_idx;
            now_q <= q_now;
            slot  <= '0;
            kept  <= '0;
            count <= '0;
            if (q_flags.is_full) begin
              allowed      <= 1'b0;
              table_full   <= 1'b1;
              logged_count <= 6'd0;
              state        <= B_OUT;
            end else if (q_flags.is_new) begin
              state <= B_DECIDE;
            end else begin
              state <= B_CNT_RD;
            end
          end
        end
        B_CNT_RD: state <= B_CNT_GOT;
        B_CNT_GOT: begin
          count <= (32'(cnt_rd) > 32'(MAX_LOG)) ? CNT_W'(MAX_LOG) : cnt_rd;
          state <= (cnt_rd == '0) ? B_DECIDE : B_LOG_RD;
        end
        B_LOG_RD: state <= B_LOG_CHK;
        B_LOG_CHK: begin
          if (keep) kept <= kept + CNT_W'(1);
          slot  <= slot + CNT_W'(1);
          state <= (slot + CNT_W'(1) == count) ? B_DECIDE : B_LOG_RD;
        end
        B_DECIDE: begin
          kept         <= kept_final;
          allowed      <= allow_now;
          table_full   <= 1'b0;
          logged_count <= (32'(kept_final) > 32'(swlrl_pkg::COUNT_SAT))
                          ? 6'(swlrl_pkg::COUNT_SAT) : 6'(kept_final);
          state        <= B_OUT;
        end
        B_OUT: begin
          if (!out_stall) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // a full table never admits and reports no log
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> !allowed && logged_count == 6'd0)
    else $error("table_full result admitted or counted");

  // an admitted request is always in its own log
  a_allowed_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && allowed |-> logged_count != 6'd0 && !table_full)
    else $error("allowed result with empty log");

  // the compacted log never outgrows its depth
  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    32'(kept) <= 32'(MAX_LOG))
    else $error("log count beyond depth");

  // no job is taken while a result is pending
  a_no_pop_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !q_pop)
    else $error("job popped with result pending");
`endif

endmodule
`default_nettype wire

// ----- sv/sliding_window_log_rate_limiter_top.sv -----
// Sliding-window-log rate limiter.
// Input channel (in_valid/in_stall) carries a word of client_key and
// now_seconds; it is taken at an edge with in_valid high and in_stall low.
// Output channel (out_valid/out_stall) returns allowed, table_full and
// logged_count, one word per input word, in order.
// Configuration: cfg_write with cfg_index 0 sets the request limit, 1 sets
// the window length; write only while the block is idle.
// The front end scans known clients one stored entry at a time (key store
// read then compare); the back end rewrites the client's log one stored
// time at a time (read then keep test). A two-word queue between them lets
// the lookup of the next word overlap the log update of the current one, so
// throughput is set by the slower of the two scans.
// Reset clears the client table (fill count), the queue and both sequencers;
// registers return to 10 requests per 60 seconds. No clearing pass is needed.
// While out_stall is high the result holds and the back end waits; the front
// end keeps accepting until the queue fills.
`default_nettype none
module sliding_window_log_rate_limiter_top #(
  parameter int NUM_ENTRIES = swlrl_pkg::NUM_ENTRIES_DEF,
  parameter int MAX_LOG     = swlrl_pkg::MAX_LOG_DEF,
  parameter int KEY_BITS    = swlrl_pkg::KEY_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [swlrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [swlrl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [31:0]                      client_key,
  input  wire logic [31:0]                      now_seconds,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  allowed,
  output logic                                  table_full,
  output logic [5:0]                            logged_count
);

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int JOB_W = IDX_W + $bits(swlrl_pkg::job_flags_t) + 32;

  logic [5:0]            req_limit;
  logic [15:0]           win_len;

  logic                  f_push;
  logic [IDX_W-1:0]      f_idx;
  swlrl_pkg::job_flags_t f_flags;
  logic [31:0]           f_now;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  logic [JOB_W-1:0]      q_out;
  logic [IDX_W-1:0]      b_idx;
  swlrl_pkg::job_flags_t b_flags;
  logic [31:0]           b_now;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      req_limit <= swlrl_pkg::REQ_LIMIT_RST;
      win_len   <= swlrl_pkg::WIN_LEN_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        swlrl_pkg::REG_REQ_LIMIT: req_limit <= cfg_data[5:0];
        swlrl_pkg::REG_WIN_LEN:   win_len   <= cfg_data;
        default: ;
      endcase
    end
  end

  swlrl_front #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .KEY_BITS    (KEY_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .client_key  (client_key),
    .now_seconds (now_seconds),
    .q_push      (f_push),
    .q_full      (q_full),
    .q_idx       (f_idx),
    .q_flags     (f_flags),
    .q_now       (f_now)
  );

  swlrl_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .data_in  ({f_idx, f_flags, f_now}),
    .full     (q_full),
    .pop      (q_pop),
    .data_out (q_out),
    .empty    (q_empty)
  );

  assign {b_idx, b_flags, b_now} = q_out;

  swlrl_back #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .MAX_LOG     (MAX_LOG)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_idx        (b_idx),
    .q_flags      (b_flags),
    .q_now        (b_now),
    .req_limit    (req_limit),
    .win_len      (win_len),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .allowed      (allowed),
    .table_full   (table_full),
    .logged_count (logged_count)
  );

endmodule
`default_nettype wire
